// ===== src/bmg_pkg.sv =====
// Shared constants and types for the Box-Muller Gaussian sample core.
// Used by the log, square-root and Horner cells and by the top level.
package bmg_pkg;

  // Fixed-point constants
  localparam logic [30:0] ONE_Q30     = 31'h4000_0000;
  localparam logic [28:0] TWO_LN2_Q28 = 29'd372130559;
  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;

  // Datapath widths
  localparam int MANT_W  = 31;  // log mantissa, Q1.30
  localparam int FRAC_W  = 30;  // log2 fraction bits
  localparam int D_W     = 36;  // -log2 distance, Q.30
  localparam int R_W     = 30;  // -2 ln u1, Q.24
  localparam int ROOT_W  = 27;  // radius, Q.24
  localparam int RAD_W   = 54;  // radicand r * 2^24
  localparam int REM_W   = 31;  // square-root remainder
  localparam int X2_W    = 32;  // angle squared, Q.30
  localparam int H_W     = 31;  // Horner term, Q.30
  localparam int SIN_W   = 31;  // |sin|, Q.30
  localparam int SIDE_W  = 32;  // angle (31 bits) and sign carried by the Horner cells
  localparam int MEAN_W  = 11;
  localparam int SIGMA_W = 8;
  localparam int SMP_W   = 12;

  // Configuration register indexes
  typedef enum logic [0:0] {
    REG_MEAN_OFFSET = 1'b0,
    REG_SIGMA_SCALE = 1'b1
  } cfg_reg_t;

  // Pipeline control shared by every cell
  typedef struct packed {
    logic en;
  } pipe_ctl_t;

endpackage

// ===== src/bmg_log_cell.sv =====
// One bit of the log2 fraction: square the mantissa, renormalise, emit one bit.
// Depends on bmg_pkg.
module bmg_log_cell import bmg_pkg::*; #(
  parameter int BIT_POS = 29,
  parameter int P_W     = 4
) (
  input  logic              clk,
  input  pipe_ctl_t         ctl,
  input  logic [MANT_W-1:0] mant_in,
  input  logic [FRAC_W-1:0] frac_in,
  input  logic [P_W-1:0]    exp_in,
  output logic [MANT_W-1:0] mant_out,
  output logic [FRAC_W-1:0] frac_out,
  output logic [P_W-1:0]    exp_out
);

  logic [2*MANT_W-1:0] sq;
  logic [MANT_W:0]     sq30;

  // Square and drop thirty fraction bits
  assign sq   = mant_in * mant_in;
  assign sq30 = sq[2*MANT_W-1:30];

  // Halve when the square reaches two and record the bit
  always_ff @(posedge clk) begin
    if (ctl.en) begin
      exp_out <= exp_in;
      if (sq30[MANT_W]) begin
        mant_out <= sq30[MANT_W:1];
        frac_out <= frac_in | (FRAC_W'(1) << BIT_POS);
      end else begin
        mant_out <= sq30[MANT_W-1:0];
        frac_out <= frac_in;
      end
    end
  end

endmodule

// ===== src/bmg_sqrt_cell.sv =====
// One root bit of the digit-by-digit integer square root.
// Depends on bmg_pkg.
module bmg_sqrt_cell import bmg_pkg::*; (
  input  logic              clk,
  input  pipe_ctl_t         ctl,
  input  logic [REM_W-1:0]  rem_in,
  input  logic [ROOT_W-1:0] root_in,
  input  logic [RAD_W-1:0]  rad_in,
  output logic [REM_W-1:0]  rem_out,
  output logic [ROOT_W-1:0] root_out,
  output logic [RAD_W-1:0]  rad_out
);

  logic [REM_W-1:0] rem2;
  logic [REM_W-1:0] trial;

  // Bring down the next two radicand bits and try the next root bit
  assign rem2  = {rem_in[REM_W-3:0], rad_in[RAD_W-1:RAD_W-2]};
  assign trial = REM_W'({root_in, 2'b01});

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      rad_out <= {rad_in[RAD_W-3:0], 2'b00};
      if (rem2 >= trial) begin
        rem_out  <= rem2 - trial;
        root_out <= {root_in[ROOT_W-2:0], 1'b1};
      end else begin
        rem_out  <= rem2;
        root_out <= {root_in[ROOT_W-2:0], 1'b0};
      end
    end
  end

endmodule

// ===== src/bmg_horner_cell.sv =====
// One Horner step of the sine series: h' = 1 - ((x2 * h) >> 30) / DIVISOR.
// Three stages: product, reciprocal multiply, correction. Depends on bmg_pkg.
module bmg_horner_cell import bmg_pkg::*; #(
  parameter int DIVISOR = 6
) (
  input  logic              clk,
  input  pipe_ctl_t         ctl,
  input  logic [X2_W-1:0]   x2_in,
  input  logic [H_W-1:0]    h_in,
  input  logic [SIDE_W-1:0] side_in,
  output logic [X2_W-1:0]   x2_out,
  output logic [H_W-1:0]    h_out,
  output logic [SIDE_W-1:0] side_out
);

  localparam logic [31:0] RECIP = 32'((64'd1 << 32) / DIVISOR);
  localparam logic [31:0] DIV_C = 32'(DIVISOR);

  logic [X2_W+H_W-1:0] prod;
  logic [X2_W-1:0]     x2_a, x2_b;
  logic [SIDE_W-1:0]   side_a, side_b;
  logic [31:0]         y;
  logic [63:0]         est;
  logic [31:0]         q0, q0k, rem, quo;

  // Stage A: product
  always_ff @(posedge clk) begin
    if (ctl.en) begin
      prod   <= x2_in * h_in;
      x2_a   <= x2_in;
      side_a <= side_in;
    end
  end

  // Stage B: quotient estimate by reciprocal, low by at most one
  always_ff @(posedge clk) begin
    if (ctl.en) begin
      y      <= prod[61:30];
      est    <= prod[61:30] * RECIP;
      x2_b   <= x2_a;
      side_b <= side_a;
    end
  end

  // Stage C: correct the estimate and form the next term
  assign q0  = est[63:32];
  assign q0k = q0 * DIV_C;
  assign rem = y - q0k;
  assign quo = (rem >= DIV_C) ? q0 + 32'd1 : q0;

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      h_out    <= H_W'(32'(ONE_Q30) - quo);
      x2_out   <= x2_b;
      side_out <= side_b;
    end
  end

endmodule

// ===== src/box_muller_gaussian_sample_core.sv =====
// Box-Muller Gaussian sample core: top level, input staging, output stage.
// Depends on bmg_pkg, bmg_log_cell, bmg_sqrt_cell and bmg_horner_cell.
//
//  channel  | dir | fields
//  ---------+-----+-----------------------------------------------
//  s_*      | in  | tdata: radius_uniform, angle_uniform
//  m_*      | out | tdata: gauss_sample; tuser: clipped
//  cfg_*    | in  | register write: mean_offset (0), sigma_scale (1)
//
//  One beat in and one beat out every cycle while the output is not stalled;
//  the radius path runs through 30 log cells and 27 square-root cells.
//  Reset clears only the valid bits and the registers; payload is not reset.
//  A stall on the output freezes the whole chain; s_tready follows it.
module box_muller_gaussian_sample_core import bmg_pkg::*; #(
  parameter int UNIFORM_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [((2*UNIFORM_BITS+7)/8)*8-1:0] s_tdata,  // radius_uniform, angle_uniform
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [15:0]            m_tdata,   // gauss_sample
  output logic                   m_tuser,   // clipped
  input  logic                   cfg_we,
  input  logic [0:0]             cfg_index,
  input  logic [MEAN_W-1:0]      cfg_data
);

  localparam int UB        = UNIFORM_BITS;
  localparam int P_W       = $clog2(UB);
  localparam int LOG_CELLS = FRAC_W;
  localparam int SQ_CELLS  = ROOT_W;
  localparam int HORNERS   = 5;
  localparam int LAT       = 65;
  localparam int SIN_END   = 3 + 3 * HORNERS + 1;
  localparam int S_END     = 1 + LOG_CELLS + 3 + SQ_CELLS;
  localparam int DLY       = S_END - SIN_END + 1;
  localparam int DIVS [HORNERS] = '{110, 72, 42, 20, 6};

  pipe_ctl_t ctl;
  logic [LAT-1:0] vld;

  // Configuration registers
  logic signed [MEAN_W-1:0] mean_offset;
  logic [SIGMA_W-1:0]       sigma_scale;

  always_ff @(posedge clk) begin
    if (rst) begin
      mean_offset <= MEAN_W'(20);
      sigma_scale <= SIGMA_W'(20);
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_MEAN_OFFSET: mean_offset <= cfg_data;
        REG_SIGMA_SCALE: sigma_scale <= cfg_data[SIGMA_W-1:0];
        default: ;
      endcase
    end
  end

  // Advance the whole chain when the output slot is free or being taken
  assign ctl.en   = !m_tvalid || m_tready;
  assign s_tready = ctl.en;
  assign m_tvalid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (ctl.en) begin
      vld <= {vld[LAT-2:0], s_tvalid};
    end
  end

  // Input fields
  logic [UB-1:0] radius_uniform, angle_uniform, rc;
  logic [P_W-1:0] top_bit;
  logic [UB+29:0] rc_wide;
  logic [31:0]    phase;

  assign radius_uniform = s_tdata[UB-1:0];
  assign angle_uniform  = s_tdata[2*UB-1:UB];
  assign rc             = (radius_uniform == '0) ? UB'(1) : radius_uniform;

  // Find the top set bit of the radius code
  always_comb begin
    top_bit = '0;
    for (int i = 0; i < UB; i++) begin
      if (rc[i]) top_bit = P_W'(i);
    end
  end

  assign rc_wide = {rc, 30'b0} >> top_bit;
  assign phase   = 32'(angle_uniform) << (32 - UB);

  // Stage 1: normalised mantissa, quadrant and angle fraction
  logic [MANT_W-1:0] mant1;
  logic [P_W-1:0]    exp1;
  logic [1:0]        quad1;
  logic [30:0]       tq1;

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      mant1 <= MANT_W'(rc_wide);
      exp1  <= top_bit;
      quad1 <= phase[31:30];
      tq1   <= phase[30] ? 31'(ONE_Q30) - 31'(phase[29:0]) : 31'(phase[29:0]);
    end
  end

  // Log chain
  logic [MANT_W-1:0] lm [LOG_CELLS+1];
  logic [FRAC_W-1:0] lf [LOG_CELLS+1];
  logic [P_W-1:0]    lp [LOG_CELLS+1];

  assign lm[0] = mant1;
  assign lf[0] = '0;
  assign lp[0] = exp1;

  for (genvar g = 0; g < LOG_CELLS; g++) begin : g_log
    bmg_log_cell #(.BIT_POS(FRAC_W - 1 - g), .P_W(P_W)) u_cell (
      .clk(clk), .ctl(ctl),
      .mant_in(lm[g]), .frac_in(lf[g]), .exp_in(lp[g]),
      .mant_out(lm[g+1]), .frac_out(lf[g+1]), .exp_out(lp[g+1])
    );
  end

  // Distance below one, then -2 ln u1 by split constant multiply
  logic [D_W-1:0] log_gap;
  logic [46:0]    pp_lo, pp_hi;
  logic [65:0]    pp_sum;
  logic [R_W-1:0] rad_r;

  assign pp_sum = (66'(pp_hi) << 18) + 66'(pp_lo);

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      log_gap <= (D_W'(UB) << 30) - D_W'({lp[LOG_CELLS], lf[LOG_CELLS]});
      pp_lo   <= log_gap[17:0] * TWO_LN2_Q28;
      pp_hi   <= log_gap[35:18] * TWO_LN2_Q28;
      rad_r   <= pp_sum[63:34];
    end
  end

  // Square-root chain
  logic [REM_W-1:0]  sr [SQ_CELLS+1];
  logic [ROOT_W-1:0] sq [SQ_CELLS+1];
  logic [RAD_W-1:0]  sv [SQ_CELLS+1];

  assign sr[0] = '0;
  assign sq[0] = '0;
  assign sv[0] = {rad_r, 24'b0};

  for (genvar g = 0; g < SQ_CELLS; g++) begin : g_sqrt
    bmg_sqrt_cell u_cell (
      .clk(clk), .ctl(ctl),
      .rem_in(sr[g]), .root_in(sq[g]), .rad_in(sv[g]),
      .rem_out(sr[g+1]), .root_out(sq[g+1]), .rad_out(sv[g+1])
    );
  end

  // Sine path: angle in radians, its square, Horner chain
  logic [61:0]       xprod;
  logic [30:0]       ang2, ang3;
  logic [1:0]        quad2, quad3;
  logic [61:0]       x2prod;
  logic [X2_W-1:0]   hx [HORNERS+1];
  logic [H_W-1:0]    hh [HORNERS+1];
  logic [SIDE_W-1:0] hs [HORNERS+1];

  assign xprod  = tq1 * HALF_PI_Q30;
  assign x2prod = ang2 * ang2;

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      ang2  <= xprod[60:30];
      quad2 <= quad1;
      hx[0] <= x2prod[61:30];
      ang3  <= ang2;
      quad3 <= quad2;
    end
  end

  assign hh[0] = ONE_Q30;
  assign hs[0] = {ang3, quad3[1]};

  for (genvar g = 0; g < HORNERS; g++) begin : g_horner
    bmg_horner_cell #(.DIVISOR(DIVS[g])) u_cell (
      .clk(clk), .ctl(ctl),
      .x2_in(hx[g]), .h_in(hh[g]), .side_in(hs[g]),
      .x2_out(hx[g+1]), .h_out(hh[g+1]), .side_out(hs[g+1])
    );
  end

  logic [61:0]      snprod;
  logic [SIN_W:0]   sin_line [DLY];

  assign snprod = hs[HORNERS][SIDE_W-1:1] * hh[HORNERS];

  // Hold |sin| and sign until the radius arrives
  always_ff @(posedge clk) begin
    if (ctl.en) begin
      sin_line[0] <= {snprod[60:30], hs[HORNERS][0]};
      for (int i = 1; i < DLY; i++) sin_line[i] <= sin_line[i-1];
    end
  end

  // Product, rounding, scaling and offset
  logic [ROOT_W+SIN_W-1:0] zprod;
  logic                    neg_a;
  logic signed [16:0]      zval;
  logic signed [24:0]      vsum;
  logic [ROOT_W+SIN_W-1:0] zround;

  assign zround = zprod + (ROOT_W+SIN_W)'(64'd1 << 41);

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      zprod <= sq[SQ_CELLS] * sin_line[DLY-1][SIN_W:1];
      neg_a <= sin_line[DLY-1][0];
      zval  <= neg_a ? -$signed({1'b0, zround[57:42]}) : $signed({1'b0, zround[57:42]});
      vsum  <= (25'(mean_offset) <<< 12)
             + 25'($signed({1'b0, sigma_scale})) * 25'(zval);
    end
  end

  // Truncate toward zero and saturate
  logic [24:0]        vabs;
  logic signed [13:0] smp;
  logic [SMP_W-1:0]   smp_sat;
  logic               clip;

  assign vabs = vsum[24] ? 25'(-vsum) : 25'(vsum);
  assign smp  = vsum[24] ? -$signed(14'(vabs >> 12)) : $signed(14'(vabs >> 12));

  always_comb begin
    clip    = 1'b0;
    smp_sat = smp[SMP_W-1:0];
    if (smp > 14'sd2047) begin
      smp_sat = 12'h7FF;
      clip    = 1'b1;
    end else if (smp < -14'sd2048) begin
      smp_sat = 12'h800;
      clip    = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      m_tdata <= {4'b0, smp_sat};
      m_tuser <= clip;
    end
  end

endmodule

// ===== src/bmg_checker.sv =====
// Port-level checks for the Gaussian sample core, bound to the top level.
// Depends on box_muller_gaussian_sample_core port names.
module bmg_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic        m_tuser
);

  // Input side stalls exactly when an output beat is held
  a_ready: assert property (@(posedge clk) disable iff (rst)
    s_tready == (!m_tvalid || m_tready)) else $error("ready does not track output slot");

  // A saturated beat carries a range limit
  a_clip: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> (m_tdata[11:0] == 12'h7FF || m_tdata[11:0] == 12'h800))
    else $error("clipped beat not at range limit");

  // Padding bits stay zero
  a_pad: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[15:12] == 4'b0) else $error("padding bits set");

  // Nothing leaves right after reset
  a_rst: assert property (@(posedge clk) rst |=> !m_tvalid) else $error("valid after reset");

  // A held beat stays valid
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid) else $error("beat dropped under stall");

endmodule

bind box_muller_gaussian_sample_core bmg_checker u_bmg_checker (.*);

// ===== dv/box_muller_gaussian_sample_core_test.sv =====
// Self-checking testbench for box_muller_gaussian_sample_core.
// Depends on bmg_pkg and the core; it predicts each Gaussian sample in fixed point.
`timescale 1ns / 1ps

module box_muller_gaussian_sample_core_test import bmg_pkg::*;;

  localparam int LATENCY = 65;
  localparam int DRAIN   = LATENCY + 10;
  localparam int LIMIT   = 400000;

  typedef struct {
    logic [15:0] radius;
    logic [15:0] angle;
  } uniform_pair_t;

  typedef struct {
    logic [11:0] sample;
    logic        clip;
  } gauss_beat_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;   // radius_uniform [15:0], angle_uniform [31:16]
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;   // gauss_sample [11:0]
  logic        m_tuser;   // clipped
  logic        cfg_we;
  logic [0:0]  cfg_index;
  logic [10:0] cfg_data;

  box_muller_gaussian_sample_core dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Local copy of the configuration
  logic signed [10:0] mean_reg;
  logic [7:0]         sigma_reg;

  uniform_pair_t pending_pairs[$];
  gauss_beat_t   expected_samples[$];

  int  send_idle_pct;
  int  recv_idle_pct;
  int  hold_cycles;
  int  queued_count;
  int  accepted_count;
  int  checked_count;
  int  clip_count;
  int  mismatch_count;
  int  cycle_count;
  bit  beat_taken;

  // log2 of a 16-bit code, Q.30
  function automatic longint unsigned log2_code(logic [15:0] code);
    int p;
    longint unsigned m;
    longint unsigned frac;
    p = 15;
    frac = 0;
    while (p > 0 && !code[p]) p--;
    m = longint'(code) << (30 - p);
    for (int i = 29; i >= 0; i--) begin
      m = (m * m) >> 30;
      if (m >= (64'd1 << 31)) begin
        m = m >> 1;
        frac |= 64'd1 << i;
      end
    end
    return (longint'(p) << 30) | frac;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // |sin| of a quarter-turn fraction, Horner form through x^11
  function automatic longint unsigned sin_quarter_turn(longint unsigned t);
    longint unsigned one;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned h;
    one = 64'd1 << 30;
    x  = (t * 64'd1686629713) >> 30;
    x2 = (x * x) >> 30;
    h  = one - x2 / 110;
    h  = one - ((x2 * h) >> 30) / 72;
    h  = one - ((x2 * h) >> 30) / 42;
    h  = one - ((x2 * h) >> 30) / 20;
    h  = one - ((x2 * h) >> 30) / 6;
    return (x * h) >> 30;
  endfunction

  function automatic gauss_beat_t gauss_predict(uniform_pair_t pair);
    gauss_beat_t res;
    logic [15:0] rc;
    longint d;
    longint unsigned r, s, ph, q, t, mag;
    longint z, v, smp;
    rc = (pair.radius == 0) ? 16'd1 : pair.radius;
    d = (longint'(16) << 30) - longint'(log2_code(rc));
    if (d < 0) d = 0;
    r = (longint'(d) * 64'd372130559) >> 34;
    s = int_sqrt(r << 24);
    ph = longint'(pair.angle) << 16;
    q = ph >> 30;
    t = ph & ((64'd1 << 30) - 1);
    if (q[0]) t = (64'd1 << 30) - t;
    mag = (s * sin_quarter_turn(t) + (64'd1 << 41)) >> 42;
    z = q[1] ? -longint'(mag) : longint'(mag);
    v = longint'(mean_reg) * 4096 + longint'(sigma_reg) * z;
    smp = (v >= 0) ? (v >>> 12) : -((-v) >>> 12);
    res.clip = 1'b0;
    if (smp > 2047) begin
      smp = 2047;
      res.clip = 1'b1;
    end
    if (smp < -2048) begin
      smp = -2048;
      res.clip = 1'b1;
    end
    res.sample = smp[11:0];
    return res;
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Sender: offer the next pending pair, idling at random
  always @(negedge clk) begin
    uniform_pair_t nxt;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || beat_taken) begin
      beat_taken = 1'b0;
      if (pending_pairs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = pending_pairs.pop_front();
        s_tdata  <= {nxt.angle, nxt.radius};
        s_tvalid <= 1'b1;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: stall at random, or hold off for a long stretch
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Input beats: predict and queue the expected sample
  always @(posedge clk) begin
    uniform_pair_t acc;
    cycle_count++;
    if (cycle_count > LIMIT) begin
      $display("%0t: timeout, %0d samples still expected", $time, expected_samples.size());
      $display("end of test: mismatches");
      $finish;
    end
    if (!rst && s_tvalid && s_tready) begin
      acc.radius = s_tdata[15:0];
      acc.angle  = s_tdata[31:16];
      expected_samples.push_back(gauss_predict(acc));
      accepted_count++;
      beat_taken = 1'b1;
    end
  end

  // Output beats: compare against the oldest expectation
  always @(posedge clk) begin
    gauss_beat_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_samples.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected beat, actual sample %0d clipped %0b",
                 $time, $signed(m_tdata[11:0]), m_tuser);
      end else begin
        want = expected_samples.pop_front();
        checked_count++;
        if (want.clip) clip_count++;
        if (m_tdata[11:0] !== want.sample || m_tuser !== want.clip) begin
          mismatch_count++;
          $display("%0t: mismatch, expected sample %0d clipped %0b, actual %0d clipped %0b",
                   $time, $signed(want.sample), want.clip,
                   $signed(m_tdata[11:0]), m_tuser);
        end
      end
    end
  end

  task automatic write_reg(cfg_reg_t idx, logic [10:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    if (idx == REG_MEAN_OFFSET) mean_reg = value;
    else sigma_reg = value[7:0];
  endtask

  task automatic queue_pair(logic [15:0] radius, logic [15:0] angle);
    uniform_pair_t p;
    p.radius = radius;
    p.angle  = angle;
    pending_pairs.push_back(p);
    queued_count++;
  endtask

  // Wait for every beat to go in and come out, then let the pipe settle
  task automatic drain_pipe();
    while (accepted_count < queued_count || expected_samples.size() > 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic queue_random(int n);
    logic [15:0] rad;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(3))
        0: rad = 16'($urandom_range(15));        // deep tail, large radius
        1: rad = 16'hFFFF - 16'($urandom_range(15));
        default: rad = 16'($urandom);
      endcase
      queue_pair(rad, 16'($urandom));
    end
  endtask

  initial begin
    logic [10:0] means[6];
    logic [7:0]  sigmas[6];
    means  = '{11'd20, 11'h400, 11'h3FF, 11'd0, 11'h7FF, 11'd300};
    sigmas = '{8'd20, 8'd255, 8'd255, 8'd0, 8'd128, 8'd1};
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    m_tready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_MEAN_OFFSET;
    cfg_data = '0;
    mean_reg = 11'sd20;
    sigma_reg = 8'd20;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_cycles = 0;
    queued_count = 0;
    accepted_count = 0;
    checked_count = 0;
    clip_count = 0;
    mismatch_count = 0;
    cycle_count = 0;
    beat_taken = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (int ph = 0; ph < 6; ph++) begin
      if (ph < 2) begin
        send_idle_pct = 24;
        recv_idle_pct = 45;
      end else if (ph < 4) begin
        send_idle_pct = 45;
        recv_idle_pct = 24;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (ph > 0) begin
        write_reg(REG_MEAN_OFFSET, means[ph]);
        write_reg(REG_SIGMA_SCALE, {3'b0, sigmas[ph]});
      end
      // Zero radius code, extremes of both codes and the quadrant edges
      if (ph == 0 || ph == 1) begin
        queue_pair(16'd0, 16'h4000);
        queue_pair(16'd1, 16'h4000);
        queue_pair(16'd1, 16'hC000);
        queue_pair(16'hFFFF, 16'h4000);
        queue_pair(16'h8000, 16'h0000);
        queue_pair(16'd2, 16'h8000);
        queue_pair(16'd1, 16'h0001);
        queue_pair(16'd1, 16'hFFFF);
        queue_pair(16'd3, 16'h3FFF);
        queue_pair(16'd3, 16'h4001);
        queue_pair(16'd0, 16'hBFFF);
        queue_pair(16'h5555, 16'hAAAA);
      end
      if (ph == 5) hold_cycles = 300;
      queue_random(ph == 5 ? 100 : 60);
      drain_pipe();
    end

    $display("Checked %0d samples (%0d saturated) over 6 register settings,",
             checked_count, clip_count);
    $display("with sender and receiver stalls and a long output back-pressure stretch.");
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== box_muller_gaussian_sample_core.f =====
src/bmg_pkg.sv
src/bmg_log_cell.sv
src/bmg_sqrt_cell.sv
src/bmg_horner_cell.sv
src/box_muller_gaussian_sample_core.sv
src/bmg_checker.sv
dv/box_muller_gaussian_sample_core_test.sv
